FILE: src/oll_pkg.sv
`timescale 1ns / 1ps

package oll_pkg;

    // Width of the stored values and of the slot field sent to every cell
    localparam int DATA_W = 32;
    localparam int SLOT_W = 8;

    // Match bits examined per scan cycle
    localparam int SCAN_CHUNK = 8;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT_AT  = 3'd4,
        OP_SEARCH     = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_DONE   = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_BADPOS = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP_FRONT,
        CELL_POP_BACK
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Broadcast from the controller to every cell of the chain
    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  key;
        logic [SLOT_W-1:0]         slot;
    } cell_ctrl_t;

    // Scanner report to the controller
    typedef struct packed {
        logic hit;
        logic last;
    } scan_stat_t;

    // Index of the lowest set bit of one scan chunk
    function automatic logic [2:0] first_set8(input logic [SCAN_CHUNK-1:0] bits);
        logic [2:0] idx;
        idx = '0;
        for (int k = SCAN_CHUNK - 1; k >= 0; k--) begin
            if (bits[k]) begin
                idx = 3'(k);
            end
        end
        return idx;
    endfunction

endpackage

FILE: src/oll_cell.sv
`timescale 1ns / 1ps

module oll_cell
    import oll_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cell_ctrl_t                ctrl,
    input  logic signed [DATA_W-1:0]  prev_data,
    input  logic                      prev_occ,
    input  logic signed [DATA_W-1:0]  next_data,
    input  logic                      next_occ,
    output logic signed [DATA_W-1:0]  data,
    output logic                      occ,
    output logic                      match
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     occ_reg;
    logic                     occ_next;

    // Pick the new content from self, left neighbor, right neighbor or key
    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                occ_next = prev_occ;
                if (MY_SLOT == ctrl.slot)
                begin
                    data_next = ctrl.key;
                end
                else if (MY_SLOT > ctrl.slot)
                begin
                    data_next = prev_data;
                end
            end
            CELL_POP_FRONT:
            begin
                data_next = next_data;
                occ_next  = next_occ;
            end
            CELL_POP_BACK:
            begin
                occ_next = next_occ;
            end
            default:
            begin
                data_next = data_reg;
                occ_next  = occ_reg;
            end
        endcase
    end

    // Clear occupancy under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // Advance stored value
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign occ   = occ_reg;
    assign match = occ_reg && (data_reg == ctrl.key);

endmodule

FILE: src/oll_scan.sv
`timescale 1ns / 1ps

module oll_scan
    import oll_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic                                 step,
    input  logic [CAPACITY-1:0]                  match_vec,
    output scan_stat_t                           stat,
    output logic [$clog2(CAPACITY + 1)-1:0]      hit_pos
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int NCH   = (CAPACITY + SCAN_CHUNK - 1) / SCAN_CHUNK;
    localparam int VEC_W = NCH * SCAN_CHUNK;
    localparam int CH_W  = $clog2(NCH + 1);

    logic [VEC_W-1:0] vec_reg;
    logic [LEN_W-1:0] base_reg;
    logic [CH_W-1:0]  left_reg;
    logic [2:0]       first_idx;

    // Load the match snapshot, then walk it one chunk per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else if (load)
        begin
            left_reg <= CH_W'(NCH);
        end
        else if (step && (left_reg != CH_W'(1)))
        begin
            left_reg <= left_reg - CH_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            vec_reg  <= VEC_W'(match_vec);
            base_reg <= '0;
        end
        else if (step)
        begin
            vec_reg  <= vec_reg >> SCAN_CHUNK;
            base_reg <= base_reg + LEN_W'(SCAN_CHUNK);
        end
    end

    assign first_idx = first_set8(vec_reg[SCAN_CHUNK-1:0]);
    assign stat.hit  = |vec_reg[SCAN_CHUNK-1:0];
    assign stat.last = (left_reg == CH_W'(1));
    assign hit_pos   = base_reg + LEN_W'(first_idx) + LEN_W'(1);

endmodule

FILE: src/ordered_list_engine_top.sv
`timescale 1ns / 1ps

// Ordered list engine: a bounded list of signed 32-bit values kept in a
// chain of cells, each cell holding one element and an occupied flag.
// Input channel (in_valid / in_stall) carries opcode, item_value, position;
// a transfer takes place when in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall) returns one result per request:
// status, found, found_position and list_length.
// Push, pop and insert update every cell in parallel at the transfer edge;
// their result is registered in the output register, or in the skid entry
// while the output is stalled, and the next request may transfer meanwhile.
// A search registers the per-cell match bits at the transfer edge and then
// scans them 8 bits per cycle, holding the block until a chunk shows a hit
// or the last chunk is reached; the result comes out at the end of that scan.
// An output register plus one skid entry let one request transfer while the
// previous result is stalled; in_stall rises while the skid entry is full or
// a search is scanning.
// Reset empties the list and drops any pending results; cell contents are
// not cleared since only occupied cells are ever read.
module ordered_list_engine_top
    import oll_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        opcode,
    input  logic signed [DATA_W-1:0]          item_value,
    input  logic [7:0]                        position,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic                              found,
    output logic [$clog2(CAPACITY + 1)-1:0]   found_position,
    output logic [$clog2(CAPACITY + 1)-1:0]   list_length
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((LEN_W > 8) ? LEN_W : 8) + 1;

    state_t                   state_reg;
    state_t                   state_next;
    logic [LEN_W-1:0]         count_reg;
    logic [LEN_W-1:0]         count_next;

    cell_ctrl_t               cell_ctrl;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]      cell_occ;
    logic [CAPACITY-1:0]      cell_match;

    logic                     scan_load;
    logic                     scan_step;
    scan_stat_t               scan_stat;
    logic [LEN_W-1:0]         scan_pos;

    logic                     in_fire;
    logic                     res_done;
    status_t                  res_status;
    logic                     res_found;
    logic [LEN_W-1:0]         res_pos;
    logic                     list_full;
    logic                     list_empty;
    logic                     pos_bad;

    logic                     out_valid_reg;
    logic [1:0]               out_status_reg;
    logic                     out_found_reg;
    logic [LEN_W-1:0]         out_pos_reg;
    logic [LEN_W-1:0]         out_len_reg;
    logic                     skid_valid_reg;
    logic [1:0]               skid_status_reg;
    logic                     skid_found_reg;
    logic [LEN_W-1:0]         skid_pos_reg;
    logic [LEN_W-1:0]         skid_len_reg;
    logic                     out_load;

    // Chain of cells
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [DATA_W-1:0] prv_data;
        logic                     prv_occ;
        logic signed [DATA_W-1:0] nxt_data;
        logic                     nxt_occ;

        if (g == 0)
        begin : g_head
            assign prv_data = cell_ctrl.key;
            assign prv_occ  = 1'b1;
        end
        else
        begin : g_mid_prev
            assign prv_data = cell_data[g-1];
            assign prv_occ  = cell_occ[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign nxt_data = cell_data[g];
            assign nxt_occ  = 1'b0;
        end
        else
        begin : g_mid_next
            assign nxt_data = cell_data[g+1];
            assign nxt_occ  = cell_occ[g+1];
        end

        oll_cell #(
            .IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .prev_data (prv_data),
            .prev_occ  (prv_occ),
            .next_data (nxt_data),
            .next_occ  (nxt_occ),
            .data      (cell_data[g]),
            .occ       (cell_occ[g]),
            .match     (cell_match[g])
        );
    end

    oll_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (scan_load),
        .step      (scan_step),
        .match_vec (cell_match),
        .stat      (scan_stat),
        .hit_pos   (scan_pos)
    );

    assign list_full  = (count_reg == LEN_W'(CAPACITY));
    assign list_empty = (count_reg == '0);
    assign pos_bad    = (position == 8'd0) ||
                        (CMP_W'(position) > (CMP_W'(count_reg) + CMP_W'(1)));
    assign in_stall   = (state_reg != ST_IDLE) || skid_valid_reg;
    assign in_fire    = in_valid && !in_stall;

    // Decode the request, drive the cells and form the result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cell_ctrl.op   = CELL_HOLD;
        cell_ctrl.key  = item_value;
        cell_ctrl.slot = '0;
        scan_load      = 1'b0;
        scan_step      = 1'b0;
        res_done       = 1'b0;
        res_status     = STAT_DONE;
        res_found      = 1'b0;
        res_pos        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_done = 1'b1;
                    case (opcode_t'(opcode))
                        OP_PUSH_FRONT:
                        begin
                            if (list_full)
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                cell_ctrl.op = CELL_INSERT;
                                count_next   = count_reg + LEN_W'(1);
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (list_full)
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                cell_ctrl.op   = CELL_INSERT;
                                cell_ctrl.slot = SLOT_W'(count_reg);
                                count_next     = count_reg + LEN_W'(1);
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (list_empty)
                            begin
                                res_status = STAT_EMPTY;
                            end
                            else
                            begin
                                cell_ctrl.op = CELL_POP_FRONT;
                                count_next   = count_reg - LEN_W'(1);
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (list_empty)
                            begin
                                res_status = STAT_EMPTY;
                            end
                            else
                            begin
                                cell_ctrl.op = CELL_POP_BACK;
                                count_next   = count_reg - LEN_W'(1);
                            end
                        end
                        OP_INSERT_AT:
                        begin
                            if (pos_bad)
                            begin
                                res_status = STAT_BADPOS;
                            end
                            else if (list_full)
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                cell_ctrl.op   = CELL_INSERT;
                                cell_ctrl.slot = SLOT_W'(position - 8'd1);
                                count_next     = count_reg + LEN_W'(1);
                            end
                        end
                        OP_SEARCH:
                        begin
                            res_done   = 1'b0;
                            scan_load  = 1'b1;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            res_status = STAT_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                scan_step = 1'b1;
                if (scan_stat.hit)
                begin
                    res_done   = 1'b1;
                    res_found  = 1'b1;
                    res_pos    = scan_pos;
                    state_next = ST_IDLE;
                end
                else if (scan_stat.last)
                begin
                    res_done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Output register is free when empty or its transfer completes now
    assign out_load = !out_valid_reg || !out_stall;

    // Advance the output register and the skid entry; a new result only
    // arrives while the skid entry is empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_done)
            begin
                if (out_load)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_done)
        begin
            if (out_load)
            begin
                out_status_reg <= res_status;
                out_found_reg  <= res_found;
                out_pos_reg    <= res_pos;
                out_len_reg    <= count_next;
            end
            else
            begin
                skid_status_reg <= res_status;
                skid_found_reg  <= res_found;
                skid_pos_reg    <= res_pos;
                skid_len_reg    <= count_next;
            end
        end
        else if (out_valid_reg && !out_stall && skid_valid_reg)
        begin
            out_status_reg <= skid_status_reg;
            out_found_reg  <= skid_found_reg;
            out_pos_reg    <= skid_pos_reg;
            out_len_reg    <= skid_len_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign found          = out_found_reg;
    assign found_position = out_pos_reg;
    assign list_length    = out_len_reg;

    // Skid entry only fills behind a waiting output
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // Occupied cells always agree with the element count
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_occ) == count_reg)
        else $error("cell occupancy disagrees with element count");

    // A search never runs with a result parked in the skid entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !skid_valid_reg)
        else $error("scan active while skid entry full");

    // A scan ends by the time the last chunk has been examined
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && scan_stat.last) |=> (state_reg == ST_IDLE))
        else $error("scan ran past the last chunk");

endmodule
